/* hw/rtl/drm_pkg.sv */
package drm_pkg;

  // Command codes carried on cmd
  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_STOP = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_RAMP_STEP       = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_UPDATE_INTERVAL = 1'b1;

  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned StepW     = 9;
  localparam int unsigned IntervalW = 10;

  localparam logic [StepW-1:0]     RampStepRst       = 9'd5;
  localparam logic [IntervalW-1:0] UpdateIntervalRst = 10'd20;

  localparam logic signed [8:0] SpeedMax = 9'sd255;
  localparam logic signed [8:0] SpeedMin = -9'sd255;

  typedef logic signed [8:0] speed_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] forward;
    logic signed [15:0] steer;
  } item_t;

  // Input register contents seen by the core
  typedef struct packed {
    logic  vld;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [7:0] duty;
  } drive_t;

  typedef struct packed {
    drive_t left;
    drive_t right;
  } result_t;

  // Clamp a 16-bit demand to the speed range
  function automatic speed_t clamp16(logic signed [15:0] v);
    speed_t r;
    if (v > 16'sd255) begin
      r = SpeedMax;
    end else if (v < -16'sd255) begin
      r = SpeedMin;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Clamp a mixed sum (-510..510) to the speed range
  function automatic speed_t clamp10(logic signed [9:0] v);
    speed_t r;
    if (v > 10'sd255) begin
      r = SpeedMax;
    end else if (v < -10'sd255) begin
      r = SpeedMin;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Move cur toward tgt by step, landing on tgt instead of passing it
  function automatic speed_t ramp_toward(speed_t cur, speed_t tgt, logic [StepW-1:0] step);
    logic signed [10:0] c;
    logic signed [10:0] t;
    logic signed [10:0] s;
    logic signed [10:0] n;
    c = 11'(cur);
    t = 11'(tgt);
    s = $signed({2'b00, step});
    n = c;
    if (c < t) begin
      n = c + s;
      if (n > t) n = t;
    end else if (c > t) begin
      n = c - s;
      if (n < t) n = t;
    end
    return n[8:0];
  endfunction

  // H-bridge pins and duty for one signed speed
  function automatic drive_t drive_bits(speed_t v);
    drive_t d;
    speed_t neg;
    neg    = -v;
    d.rev  = v[8];
    d.fwd  = !v[8] && (v != '0);
    d.duty = v[8] ? neg[7:0] : v[7:0];
    return d;
  endfunction

endpackage

/* hw/rtl/drm_in_reg.sv */
module drm_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  drm_pkg::item_t     item_i,
  input  logic               advance_i,
  output logic               in_stall_o,
  output drm_pkg::stage_t    stage_o
);

  logic           vld_q, vld_d;
  drm_pkg::item_t item_q;
  logic           accept;

  // Hold the beat only while the core cannot take it
  assign in_stall_o = vld_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign stage_o.vld  = vld_q;
  assign stage_o.item = item_q;

endmodule

/* hw/rtl/drm_core.sv */
module drm_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [drm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [drm_pkg::CfgDataW-1:0]       cfg_data_i,
  input  drm_pkg::stage_t                    stage_i,
  output logic                               advance_o,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output drm_pkg::result_t                   result_o
);

  logic [drm_pkg::StepW-1:0]     step_q;
  logic [drm_pkg::IntervalW-1:0] interval_q;

  drm_pkg::speed_t left_tgt_q, left_tgt_d;
  drm_pkg::speed_t right_tgt_q, right_tgt_d;
  drm_pkg::speed_t left_cur_q, left_cur_d;
  drm_pkg::speed_t right_cur_q, right_cur_d;
  logic [drm_pkg::IntervalW-1:0] ticks_q, ticks_d;

  logic              out_vld_q, out_vld_d;
  drm_pkg::result_t  out_q, out_d;
  logic              emit;
  logic              fire;

  drm_pkg::speed_t    fwd_c, str_c;
  logic signed [9:0]  sum, dif;
  logic [drm_pkg::IntervalW:0] tick_inc;

  // Advance whenever the result register is free or being drained
  assign advance_o = !out_vld_q || !out_stall_i;
  assign fire      = stage_i.vld && advance_o;

  // Mix clamped demands
  assign fwd_c    = drm_pkg::clamp16(stage_i.item.forward);
  assign str_c    = drm_pkg::clamp16(stage_i.item.steer);
  assign sum      = 10'(fwd_c) + 10'(str_c);
  assign dif      = 10'(fwd_c) - 10'(str_c);
  assign tick_inc = {1'b0, ticks_q} + 11'd1;

  // Update state and build the result for one item
  always_comb begin
    left_tgt_d  = left_tgt_q;
    right_tgt_d = right_tgt_q;
    left_cur_d  = left_cur_q;
    right_cur_d = right_cur_q;
    ticks_d     = ticks_q;
    emit        = 1'b0;
    if (fire) begin
      case (stage_i.item.cmd)
        drm_pkg::CMD_SET: begin
          left_tgt_d  = drm_pkg::clamp10(sum);
          right_tgt_d = drm_pkg::clamp10(dif);
        end
        drm_pkg::CMD_STOP: begin
          left_tgt_d  = '0;
          right_tgt_d = '0;
          left_cur_d  = '0;
          right_cur_d = '0;
          emit        = 1'b1;
        end
        drm_pkg::CMD_TICK: begin
          if (tick_inc >= {1'b0, interval_q}) begin
            ticks_d     = '0;
            left_cur_d  = drm_pkg::ramp_toward(left_cur_q, left_tgt_q, step_q);
            right_cur_d = drm_pkg::ramp_toward(right_cur_q, right_tgt_q, step_q);
            emit        = 1'b1;
          end else begin
            ticks_d = tick_inc[drm_pkg::IntervalW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    out_d.left  = drm_pkg::drive_bits(left_cur_d);
    out_d.right = drm_pkg::drive_bits(right_cur_d);
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance_o) begin
      out_vld_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= drm_pkg::RampStepRst;
      interval_q  <= drm_pkg::UpdateIntervalRst;
      left_tgt_q  <= '0;
      right_tgt_q <= '0;
      left_cur_q  <= '0;
      right_cur_q <= '0;
      ticks_q     <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      // Take register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          drm_pkg::REG_RAMP_STEP:       step_q     <= cfg_data_i[drm_pkg::StepW-1:0];
          drm_pkg::REG_UPDATE_INTERVAL: interval_q <= cfg_data_i[drm_pkg::IntervalW-1:0];
          default: begin
          end
        endcase
      end
      left_tgt_q  <= left_tgt_d;
      right_tgt_q <= right_tgt_d;
      left_cur_q  <= left_cur_d;
      right_cur_q <= right_cur_d;
      ticks_q     <= ticks_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = out_q;

endmodule

/* hw/rtl/differential_drive_ramp_mixer.sv */
// Two-motor skid-steer mixer with ramped speeds and H-bridge drive outputs.
// Input channel (in_valid_i / in_stall_o): cmd_i selects set command (targets
// from forward_i and steer_i), stop (zero everything, emit the off drive) or
// a one millisecond tick. Every update_interval ticks the current speeds step
// toward their targets by ramp_step and a drive beat is emitted.
// Output channel (out_valid_o / out_stall_i): one beat carries direction pins
// and duty for both motors. Set commands and plain ticks emit no beat.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 ramp_step, 1 update_interval); write only while the block is idle.
// Timing: the input register loads at the accepting edge, and the result
// register loads from it once the core advances, which a stalled result
// holds off. Throughput: one beat per cycle while no result is stalled,
// set by the single pass from input register to result register.
// Reset: clears speeds, targets and the tick counter, loads ramp_step 5 and
// update_interval 20, and empties both registers.
// Stall: a waiting result holds stable; the input register still takes one
// more beat, after which in_stall_o rises until the result drains.
module differential_drive_ramp_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [drm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [15:0]            forward_i,
  input  logic signed [15:0]            steer_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          left_dir_fwd_o,
  output logic                          left_dir_rev_o,
  output logic [7:0]                    left_duty_o,
  output logic                          right_dir_fwd_o,
  output logic                          right_dir_rev_o,
  output logic [7:0]                    right_duty_o
);

  drm_pkg::item_t   item;
  drm_pkg::stage_t  stage;
  drm_pkg::result_t result;
  logic             advance;

  assign item.cmd     = cmd_i;
  assign item.forward = forward_i;
  assign item.steer   = steer_i;

  drm_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (item),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .stage_o    (stage)
  );

  drm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result)
  );

  assign left_dir_fwd_o  = result.left.fwd;
  assign left_dir_rev_o  = result.left.rev;
  assign left_duty_o     = result.left.duty;
  assign right_dir_fwd_o = result.right.fwd;
  assign right_dir_rev_o = result.right.rev;
  assign right_duty_o    = result.right.duty;

endmodule

/* hw/rtl/drm_checker.sv */
module drm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          left_dir_fwd_o,
  input logic                          left_dir_rev_o,
  input logic [7:0]                    left_duty_o,
  input logic                          right_dir_fwd_o,
  input logic                          right_dir_rev_o,
  input logic [7:0]                    right_duty_o
);

  // Stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_duty_o)
      && $stable(right_duty_o) && $stable(left_dir_fwd_o) && $stable(right_dir_fwd_o))
    else $error("stalled result beat changed");

  // Never drive both bridge inputs of one motor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(left_dir_fwd_o && left_dir_rev_o)
      && !(right_dir_fwd_o && right_dir_rev_o))
    else $error("bridge shoot-through");

  // Duty is zero exactly when both direction pins are low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((left_duty_o == 8'd0) == !(left_dir_fwd_o || left_dir_rev_o))
      && ((right_duty_o == 8'd0) == !(right_dir_fwd_o || right_dir_rev_o)))
    else $error("duty and direction disagree");

  // Input backpressure only comes from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

endmodule

bind differential_drive_ramp_mixer drm_checker u_drm_checker (.*);

/* sim/tb_differential_drive_ramp_mixer.sv */
module tb_differential_drive_ramp_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  // The one command code the package leaves unnamed
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned SpeedLimit = 255;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we_i = 1'b0;
  logic [drm_pkg::CfgIdxW-1:0]         cfg_idx_i = drm_pkg::REG_RAMP_STEP;
  logic [drm_pkg::CfgDataW-1:0]        cfg_data_i = '0;
  logic                                in_valid_i = 1'b0;
  logic                                in_stall_o;
  logic [1:0]                          cmd_i = drm_pkg::CMD_SET;
  logic signed [15:0]                  forward_i = '0;
  logic signed [15:0]                  steer_i = '0;
  logic                                out_valid_o;
  logic                                out_stall_i = 1'b0;
  logic                                left_dir_fwd_o;
  logic                                left_dir_rev_o;
  logic [7:0]                          left_duty_o;
  logic                                right_dir_fwd_o;
  logic                                right_dir_rev_o;
  logic [7:0]                          right_duty_o;

  differential_drive_ramp_mixer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .forward_i      (forward_i),
    .steer_i        (steer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_dir_fwd_o (left_dir_fwd_o),
    .left_dir_rev_o (left_dir_rev_o),
    .left_duty_o    (left_duty_o),
    .right_dir_fwd_o(right_dir_fwd_o),
    .right_dir_rev_o(right_dir_rev_o),
    .right_duty_o   (right_duty_o)
  );

  // Drive model: configuration copy, targets, current speeds, tick counter
  int unsigned model_step = drm_pkg::RampStepRst;
  int unsigned model_interval = drm_pkg::UpdateIntervalRst;
  int unsigned tick_count = 0;
  int          left_goal = 0;
  int          right_goal = 0;
  int          left_speed = 0;
  int          right_speed = 0;

  drm_pkg::item_t   cmd_backlog_q[$];
  drm_pkg::result_t drive_expect_q[$];
  int unsigned      beats_queued = 0;
  int unsigned      beats_in = 0;
  int unsigned      fail_count = 0;
  bit               in_beat_taken = 1'b0;
  int               in_gap_left = 0;
  int               in_quiet = 0;
  int               out_hold_left = 0;
  int               out_quiet = 0;
  drm_pkg::item_t   next_beat;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clamp_speed(int v);
    if (v > int'(SpeedLimit)) return SpeedLimit;
    if (v < -int'(SpeedLimit)) return -int'(SpeedLimit);
    return v;
  endfunction

  // Step toward the goal, landing on it rather than passing it
  function automatic int slew_toward(int cur, int goal, int step);
    int n;
    n = cur;
    if (cur < goal) begin
      n = cur + step;
      if (n > goal) n = goal;
    end else if (cur > goal) begin
      n = cur - step;
      if (n < goal) n = goal;
    end
    return n;
  endfunction

  function automatic drm_pkg::drive_t bridge_pins(int speed);
    drm_pkg::drive_t d;
    int mag;
    mag = (speed < 0) ? -speed : speed;
    d.fwd = speed > 0;
    d.rev = speed < 0;
    d.duty = mag[7:0];
    return d;
  endfunction

  function automatic drm_pkg::result_t drive_beat(int l, int r);
    drm_pkg::result_t res;
    res.left = bridge_pins(l);
    res.right = bridge_pins(r);
    return res;
  endfunction

  // Work out the drive beat, if any, that one command causes
  task automatic predict_drive(drm_pkg::item_t it);
    int f;
    int s;
    f = clamp_speed(int'(it.forward));
    s = clamp_speed(int'(it.steer));
    case (it.cmd)
      drm_pkg::CMD_SET: begin
        left_goal = clamp_speed(f + s);
        right_goal = clamp_speed(f - s);
      end
      drm_pkg::CMD_STOP: begin
        left_goal = 0;
        right_goal = 0;
        left_speed = 0;
        right_speed = 0;
        drive_expect_q.push_back(drive_beat(0, 0));
      end
      drm_pkg::CMD_TICK: begin
        if (tick_count + 1 >= model_interval) begin
          tick_count = 0;
          left_speed = slew_toward(left_speed, left_goal, int'(model_step));
          right_speed = slew_toward(right_speed, right_goal, int'(model_step));
          drive_expect_q.push_back(drive_beat(left_speed, right_speed));
        end else begin
          tick_count = tick_count + 1;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_failure(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_pin(string name, int got, int want);
    if (got != want) note_failure($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Mostly short gaps, a few long ones, and now and then a quiet stretch
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic signed [15:0] pick_demand();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        v = $urandom_range(0, 600) - 300;
        return v[15:0];
      end
      5: begin
        case ($urandom_range(0, 6))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sd255;
          3: return -16'sd255;
          4: return 16'sd256;
          5: return -16'sd256;
          default: return '0;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_item(logic [1:0] cmd, logic signed [15:0] f, logic signed [15:0] s);
    drm_pkg::item_t it;
    it.cmd = cmd;
    it.forward = f;
    it.steer = s;
    cmd_backlog_q.push_back(it);
    beats_queued++;
  endtask

  // Queue n commands that matter; unused codes ride along uncounted
  task automatic queue_random(int n, int tick_pct);
    int made;
    int r;
    logic [1:0] cmd;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = CMD_UNUSED;
      end else begin
        made++;
        if (r < 8) cmd = drm_pkg::CMD_STOP;
        else if (r < 8 + tick_pct) cmd = drm_pkg::CMD_TICK;
        else cmd = drm_pkg::CMD_SET;
      end
      queue_item(cmd, pick_demand(), pick_demand());
    end
  endtask

  // Wait for every beat to be taken and answered, then for the pipeline to empty
  task automatic drain();
    while (beats_in != beats_queued || drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [drm_pkg::CfgIdxW-1:0] idx,
                           logic [drm_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == drm_pkg::REG_RAMP_STEP) model_step = data[drm_pkg::StepW-1:0];
    else model_interval = data[drm_pkg::IntervalW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [drm_pkg::CfgDataW-1:0] step,
                          logic [drm_pkg::CfgDataW-1:0] interval);
    write_reg(drm_pkg::REG_RAMP_STEP, step);
    write_reg(drm_pkg::REG_UPDATE_INTERVAL, interval);
  endtask

  // Input driver: hold a beat until taken, then idle or present the next one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog_q.size() != 0) begin
        next_beat = cmd_backlog_q.pop_front();
        cmd_i <= next_beat.cmd;
        forward_i <= next_beat.forward;
        steer_i <= next_beat.steer;
        in_valid_i <= 1'b1;
        in_gap_left = pick_gap(in_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure in runs of random length
  always @(negedge clk_i) begin
    if (out_hold_left > 0) begin
      out_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_hold_left = pick_gap(out_quiet);
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: predict on each input beat, check each drive beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_beat_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        next_beat.cmd = cmd_i;
        next_beat.forward = forward_i;
        next_beat.steer = steer_i;
        predict_drive(next_beat);
        beats_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (drive_expect_q.size() == 0) begin
          note_failure("drive beat with none expected");
        end else begin
          drm_pkg::result_t want;
          want = drive_expect_q.pop_front();
          check_pin("left_dir_fwd", left_dir_fwd_o, want.left.fwd);
          check_pin("left_dir_rev", left_dir_rev_o, want.left.rev);
          check_pin("left_duty", left_duty_o, want.left.duty);
          check_pin("right_dir_fwd", right_dir_fwd_o, want.right.fwd);
          check_pin("right_dir_rev", right_dir_rev_o, want.right.rev);
          check_pin("right_duty", right_duty_o, want.right.duty);
        end
      end
    end else begin
      in_beat_taken <= 1'b0;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: clamp corners, unused code, one full update interval, stop
    queue_item(CMD_UNUSED, 16'sh7FFF, 16'sh8000);
    queue_item(drm_pkg::CMD_SET, 16'sh7FFF, 16'sh8000);
    queue_item(drm_pkg::CMD_SET, 16'sd255, 16'sd255);
    queue_item(drm_pkg::CMD_SET, -16'sd256, 16'sd256);
    queue_item(drm_pkg::CMD_SET, 16'sh8000, 16'sh8000);
    repeat (20) queue_item(drm_pkg::CMD_TICK, 16'sh7FFF, 16'sh7FFF);
    queue_item(drm_pkg::CMD_STOP, 16'sh8000, 16'sh7FFF);
    drain();

    // Zero step: speeds stay put
    set_regs(10'd0, 10'd1);
    queue_random(100, 65);
    drain();
    // Widest step, zero interval
    set_regs(10'h1FF, 10'd0);
    queue_random(150, 65);
    drain();
    set_regs(10'd1, 10'd1);
    queue_random(150, 65);
    drain();
    set_regs(10'd510, 10'd2);
    queue_random(120, 65);
    drain();
    // Longest interval: let the counter climb
    set_regs(10'd7, 10'd1023);
    queue_random(200, 88);
    drain();
    // Lowered interval with the counter already past it; step bit 9 dropped
    set_regs(10'h203, 10'd3);
    queue_random(120, 65);
    drain();
    repeat (3) begin
      set_regs(10'($urandom_range(0, 511)), 10'($urandom_range(1, 8)));
      queue_random(90, 65);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
